>>> rtl/etl_pkg.sv
// Shared types, character codes and classification helpers for the expression lexer.
`timescale 1ns / 1ps

package etl_pkg;

	// token types as seen on the result channel
	typedef enum logic [2:0] {
		TT_NUMBER   = 3'd0,
		TT_VARIABLE = 3'd1,
		TT_LPAREN   = 3'd2,
		TT_RPAREN   = 3'd3,
		TT_OPER     = 3'd4
	} tok_type_t;

	// what the lookahead register holds
	typedef enum logic [3:0] {
		HK_NONE = 4'b0001,
		HK_OP   = 4'b0010,
		HK_NUM  = 4'b0100,
		HK_VAR  = 4'b1000
	} held_kind_t;

	typedef struct packed {
		logic [7:0] ch;
		tok_type_t  ttype;
		logic       tend;
		logic       last;
	} tok_entry_t;

	localparam int unsigned QDepth = 4;
	localparam int unsigned QPtrW  = $clog2(QDepth);
	localparam int unsigned QCntW  = $clog2(QDepth + 1);

	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_BANG   = 8'h21;
	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_RPAREN = 8'h29;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_PLUS   = 8'h2B;
	localparam logic [7:0] CH_MINUS  = 8'h2D;
	localparam logic [7:0] CH_DOT    = 8'h2E;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_LT     = 8'h3C;
	localparam logic [7:0] CH_EQ     = 8'h3D;
	localparam logic [7:0] CH_GT     = 8'h3E;
	localparam logic [7:0] CH_CARET  = 8'h5E;

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= 8'h30) && (c <= 8'h39);
	endfunction

	function automatic logic is_letter(input logic [7:0] c);
		return ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A));
	endfunction

	function automatic logic is_run_char(input logic [7:0] c);
		return is_digit(c) || is_letter(c) || (c == CH_DOT);
	endfunction

	function automatic logic is_pair_start(input logic [7:0] c);
		return (c == CH_STAR) || (c == CH_EQ) || (c == CH_LT) || (c == CH_GT) ||
			(c == CH_BANG);
	endfunction

	function automatic logic is_pair(input logic [7:0] a, input logic [7:0] b);
		return ((a == CH_STAR) && (b == CH_STAR)) || ((a == CH_EQ) && (b == CH_EQ)) ||
			((a == CH_LT) && (b == CH_EQ)) || ((a == CH_GT) && (b == CH_EQ)) ||
			((a == CH_LT) && (b == CH_GT)) || ((a == CH_BANG) && (b == CH_EQ));
	endfunction

	function automatic logic is_single_op(input logic [7:0] c);
		return (c == CH_CARET) || (c == CH_SLASH) || (c == CH_STAR) ||
			(c == CH_MINUS) || (c == CH_PLUS) || (c == CH_LT) || (c == CH_GT);
	endfunction

	function automatic tok_entry_t mk_ent(input logic [7:0] c, input tok_type_t t,
		input logic e);
		tok_entry_t r;
		r.ch    = c;
		r.ttype = t;
		r.tend  = e;
		r.last  = 1'b0;
		return r;
	endfunction

endpackage

>>> rtl/expression_token_lexer_top.sv
// Expression lexer: byte stream in, typed token characters out.
//
// Usage:
//   Byte channel (byte_valid/byte_ready, ch, card_end): one expression byte per
//   request; card_end marks the last byte and flushes the held lookahead.
//   Token channel (tok_valid/tok_ready, tok_char, tok_type, tok_end, run_last):
//   one token character per request; run_last marks the final character that
//   a given input byte produced. A byte may produce zero, one or two results.
//   Flow: an accepted byte is captured in the input register and classified
//   there combinationally; its results are written into the result queue,
//   which the token channel reads from.
//   Throughput: one byte per cycle while bytes produce at most one result each
//   and tok_ready stays high; the token channel moves one result per cycle, so
//   a byte with two results needs the channel for both. The four-entry result
//   queue sets this: the input register advances only when two entries are free.
//   Reset clears the lookahead, the input register and the result queue.
//   When the receiver stalls, results collect in the queue; once it cannot take
//   two more, a held byte waits in the input register and byte_ready drops.
`timescale 1ns / 1ps

module expression_token_lexer_top (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       byte_valid,
	output logic       byte_ready,
	input  logic [7:0] ch,
	input  logic       card_end,
	output logic       tok_valid,
	input  logic       tok_ready,
	output logic [7:0] tok_char,
	output logic [2:0] tok_type,
	output logic       tok_end,
	output logic       run_last
);
	import etl_pkg::*;

	logic            valid_s1;
	logic [7:0]      ch_s1;
	logic            end_s1;

	logic [7:0]      held_char_q;
	held_kind_t      held_kind_q;

	tok_entry_t      q_mem [QDepth];
	logic [QPtrW-1:0] wr_ptr_q, rd_ptr_q;
	logic [QCntW-1:0] cnt_q;

	logic            room;
	logic            consume;
	logic            pop;

	tok_entry_t      k [3];
	logic [2:0]      k_v;
	tok_entry_t      out0, out1;
	logic [1:0]      nres;
	logic [7:0]      hc_n;
	held_kind_t      hk_n;
	logic            do_fresh;
	tok_type_t       run_t;

	assign room       = (cnt_q <= QCntW'(QDepth - 2));
	assign consume    = valid_s1 && room;
	assign byte_ready = !valid_s1 || room;
	assign pop        = tok_valid && tok_ready;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (byte_ready) begin
			valid_s1 <= byte_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_ready && byte_valid) begin
			ch_s1  <= ch;
			end_s1 <= card_end;
		end
	end

	// classification: held part, fresh char, card-end flush
	always_comb begin
		k_v      = 3'b000;
		k[0]     = '0;
		k[1]     = '0;
		k[2]     = '0;
		hc_n     = held_char_q;
		hk_n     = held_kind_q;
		do_fresh = 1'b0;
		run_t    = (held_kind_q == HK_NUM) ? TT_NUMBER : TT_VARIABLE;

		case (held_kind_q)
			HK_OP: begin
				if (is_pair(held_char_q, ch_s1)) begin
					k_v[0] = 1'b1;
					k[0]   = mk_ent(held_char_q, TT_OPER, 1'b0);
					k_v[1] = 1'b1;
					k[1]   = mk_ent(ch_s1, TT_OPER, 1'b1);
				end else begin
					k_v[0]   = is_single_op(held_char_q);
					k[0]     = mk_ent(held_char_q, TT_OPER, 1'b1);
					do_fresh = 1'b1;
				end
				hc_n = 8'h00;
				hk_n = HK_NONE;
			end
			HK_NUM, HK_VAR: begin
				if (is_run_char(ch_s1)) begin
					k_v[0] = 1'b1;
					k[0]   = mk_ent(held_char_q, run_t, 1'b0);
					hc_n   = ch_s1;
				end else begin
					k_v[0]   = 1'b1;
					k[0]     = mk_ent(held_char_q, run_t, 1'b1);
					hc_n     = 8'h00;
					hk_n     = HK_NONE;
					do_fresh = 1'b1;
				end
			end
			default: begin
				do_fresh = 1'b1;
			end
		endcase

		if (do_fresh) begin
			if (ch_s1 == CH_SPACE) begin
				k_v[1] = 1'b0;
			end else if (ch_s1 == CH_LPAREN) begin
				k_v[1] = 1'b1;
				k[1]   = mk_ent(ch_s1, TT_LPAREN, 1'b1);
			end else if (ch_s1 == CH_RPAREN) begin
				k_v[1] = 1'b1;
				k[1]   = mk_ent(ch_s1, TT_RPAREN, 1'b1);
			end else if (is_pair_start(ch_s1)) begin
				hc_n = ch_s1;
				hk_n = HK_OP;
			end else if (is_single_op(ch_s1)) begin
				k_v[1] = 1'b1;
				k[1]   = mk_ent(ch_s1, TT_OPER, 1'b1);
			end else if (is_run_char(ch_s1)) begin
				hc_n = ch_s1;
				hk_n = (is_digit(ch_s1) || (ch_s1 == CH_DOT)) ? HK_NUM : HK_VAR;
			end
		end

		// card end: flush whatever is held after this byte
		if (end_s1) begin
			case (hk_n)
				HK_OP: begin
					k_v[2] = is_single_op(hc_n);
					k[2]   = mk_ent(hc_n, TT_OPER, 1'b1);
				end
				HK_NUM: begin
					k_v[2] = 1'b1;
					k[2]   = mk_ent(hc_n, TT_NUMBER, 1'b1);
				end
				HK_VAR: begin
					k_v[2] = 1'b1;
					k[2]   = mk_ent(hc_n, TT_VARIABLE, 1'b1);
				end
				default: begin
					k_v[2] = 1'b0;
				end
			endcase
			hc_n = 8'h00;
			hk_n = HK_NONE;
		end

		// compact up to two valid candidates, in order
		nres = 2'(k_v[0]) + 2'(k_v[1]) + 2'(k_v[2]);
		out0 = k_v[0] ? k[0] : (k_v[1] ? k[1] : k[2]);
		out1 = k_v[0] ? (k_v[1] ? k[1] : k[2]) : k[2];
		out0.last = (nres == 2'd1);
		out1.last = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_char_q <= 8'h00;
			held_kind_q <= HK_NONE;
		end else if (consume) begin
			held_char_q <= hc_n;
			held_kind_q <= hk_n;
		end
	end

	// result queue
	always_ff @(posedge clk) begin
		if (consume && (nres != 2'd0)) begin
			q_mem[wr_ptr_q] <= out0;
		end
		if (consume && (nres == 2'd2)) begin
			q_mem[wr_ptr_q + QPtrW'(1)] <= out1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (consume) begin
				wr_ptr_q <= wr_ptr_q + QPtrW'(nres);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPtrW'(1);
			end
			cnt_q <= cnt_q + (consume ? QCntW'(nres) : QCntW'(0)) - QCntW'(pop);
		end
	end

	assign tok_valid = (cnt_q != '0);
	assign tok_char  = q_mem[rd_ptr_q].ch;
	assign tok_type  = q_mem[rd_ptr_q].ttype;
	assign tok_end   = q_mem[rd_ptr_q].tend;
	assign run_last  = q_mem[rd_ptr_q].last;

endmodule
